[rtl/dtsi_pkg.sv]
// shared types, codes and character constants of the decimal text parser
// no dependencies; imported by every module of the block
package dtsi_pkg;

   localparam int FRACTION_COUNT_BITS = 32;
   localparam int CHAR_W  = 8;
   localparam int COEF_W  = 63;
   localparam int EXPO_W  = 64;
   localparam int CODE_W  = 4;

   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_E_UPPER = 8'h45;
   localparam logic [CHAR_W-1:0] CHAR_E_LOWER = 8'h65;

   localparam logic [EXPO_W-1:0] POS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [EXPO_W-1:0] NEG_MAX     = 64'h8000_0000_0000_0000;
   localparam logic [EXPO_W-1:0] TENTH_LIMIT = 64'd922337203685477580;

   typedef enum logic [CODE_W-1:0] {
      ERR_OK         = 4'd0,
      ERR_SIGN_EMPTY = 4'd1,
      ERR_MULTI_EXP  = 4'd2,
      ERR_BAD_EXP    = 4'd3,
      ERR_EMPTY_EXP  = 4'd4,
      ERR_MULTI_DOT  = 4'd5,
      ERR_INCOMPLETE = 4'd6,
      ERR_NONDIGIT   = 4'd7,
      ERR_ZERO       = 4'd8,
      ERR_COEF_RANGE = 4'd9,
      ERR_EXP_RANGE  = 4'd10
   } dtsi_err_type;

   // one registered input item
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] char_code;
      logic              present;
      logic              last;
   } dtsi_item_type;

   // parse state without the fraction count, whose width is a parameter
   typedef struct packed {
      logic              sign_err;
      logic              nondigit;
      logic              bad_exp;
      logic [1:0]        char_count;
      logic [1:0]        dot_count;
      logic [1:0]        exp_count;
      logic              int_nonzero;
      logic [COEF_W-1:0] coef;
      logic              coef_ovf;
      logic [EXPO_W-1:0] exp_mag;
      logic              exp_neg;
      logic              exp_digit;
      logic              exp_ovf;
   } dtsi_state_type;

endpackage

[rtl/dtsi_parser.sv]
// per-character parse state update and end-of-string snapshot register
// depends on dtsi_pkg
module dtsi_parser #(
   parameter int FRACTION_COUNT_BITS = dtsi_pkg::FRACTION_COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dtsi_pkg::dtsi_item_type        item,
   input  logic                           slot_free,
   output logic                           consume,
   output logic                           snap_valid,
   output dtsi_pkg::dtsi_state_type       snap,
   output logic [FRACTION_COUNT_BITS-1:0] snap_frac
);
   import dtsi_pkg::*;

   localparam logic [FRACTION_COUNT_BITS-1:0] FRAC_MAX = '1;
   localparam logic [FRACTION_COUNT_BITS-1:0] FRAC_ONE = FRACTION_COUNT_BITS'(1);

   dtsi_state_type                 st_ff, st_in, upd;
   logic [FRACTION_COUNT_BITS-1:0] frac_ff, frac_in, upd_frac;
   dtsi_state_type                 snap_ff, snap_in;
   logic [FRACTION_COUNT_BITS-1:0] snap_frac_ff, snap_frac_in;
   logic                           snap_valid_ff, snap_valid_in;
   logic                           snap_free;

   logic [CHAR_W-1:0] c;
   logic              is_digit;
   logic [3:0]        digit;
   logic [EXPO_W-1:0] digit64;
   logic [EXPO_W-1:0] coef64;
   logic [EXPO_W-1:0] coef_next;
   logic [EXPO_W-1:0] mag_next;
   logic              text_empty;

   always_comb begin
      c         = item.char_code;
      is_digit  = c inside {[CHAR_ZERO:CHAR_NINE]};
      digit     = 4'(c - CHAR_ZERO);
      digit64   = {60'd0, digit};
      coef64    = {1'b0, st_ff.coef};
      // times ten as two shifts and one add
      coef_next = (coef64 << 3) + (coef64 << 1) + digit64;
      mag_next  = (st_ff.exp_mag << 3) + (st_ff.exp_mag << 1) + digit64;
      text_empty = !st_ff.exp_neg && !st_ff.exp_digit && !st_ff.bad_exp;

      upd      = st_ff;
      upd_frac = frac_ff;
      if (item.present) begin
         if (st_ff.char_count == 2'd0 && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            upd.sign_err = 1'b1;
         end
         if (st_ff.char_count != 2'd3) begin
            upd.char_count = st_ff.char_count + 2'd1;
         end
         if (c == CHAR_E_LOWER || c == CHAR_E_UPPER) begin
            if (st_ff.exp_count != 2'd2) begin
               upd.exp_count = st_ff.exp_count + 2'd1;
            end
            if (st_ff.exp_count != 2'd0) begin
               upd.bad_exp = 1'b1;
            end
         end else if (st_ff.exp_count != 2'd0) begin
            // exponent text
            if (c == CHAR_MINUS && text_empty) begin
               upd.exp_neg = 1'b1;
            end else if (is_digit) begin
               upd.exp_digit = 1'b1;
               if (!st_ff.exp_ovf) begin
                  if (st_ff.exp_mag > TENTH_LIMIT || mag_next > NEG_MAX) begin
                     upd.exp_ovf = 1'b1;
                  end else begin
                     upd.exp_mag = mag_next;
                  end
               end
            end else begin
               upd.bad_exp = 1'b1;
            end
         end else if (c == CHAR_DOT) begin
            if (st_ff.dot_count != 2'd2) begin
               upd.dot_count = st_ff.dot_count + 2'd1;
            end
         end else begin
            // mantissa character other than a dot
            if (st_ff.dot_count == 2'd0) begin
               upd.int_nonzero = 1'b1;
            end else if (frac_ff != FRAC_MAX) begin
               upd_frac = frac_ff + FRAC_ONE;
            end
            if (!is_digit) begin
               upd.nondigit = 1'b1;
            end else if (!st_ff.coef_ovf) begin
               if (coef64 > TENTH_LIMIT || coef_next[EXPO_W-1]) begin
                  upd.coef_ovf = 1'b1;
               end else begin
                  upd.coef = coef_next[COEF_W-1:0];
               end
            end
         end
      end
   end

   always_comb begin
      snap_free = !snap_valid_ff || slot_free;
      consume   = item.valid && (!item.last || snap_free);

      st_in         = st_ff;
      frac_in       = frac_ff;
      snap_in       = snap_ff;
      snap_frac_in  = snap_frac_ff;
      snap_valid_in = snap_valid_ff && !slot_free;
      if (consume) begin
         if (item.last) begin
            snap_in       = upd;
            snap_frac_in  = upd_frac;
            snap_valid_in = 1'b1;
            st_in         = '0;
            frac_in       = '0;
         end else begin
            st_in   = upd;
            frac_in = upd_frac;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= '0;
         frac_ff       <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         frac_ff       <= frac_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff      <= snap_in;
      snap_frac_ff <= snap_frac_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;
   assign snap_frac  = snap_frac_ff;

endmodule

[rtl/dtsi_judge.sv]
// error priority, final exponent and the result register
// depends on dtsi_pkg
module dtsi_judge #(
   parameter int FRACTION_COUNT_BITS = dtsi_pkg::FRACTION_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              snap_valid,
   input  dtsi_pkg::dtsi_state_type          snap,
   input  logic [FRACTION_COUNT_BITS-1:0]    snap_frac,
   input  logic                              permit_zero,
   input  logic                              rsp_ready,
   output logic                              slot_free,
   output logic                              rsp_valid,
   output dtsi_pkg::dtsi_err_type            rsp_code,
   output logic [dtsi_pkg::COEF_W-1:0]       rsp_coef,
   output logic [dtsi_pkg::EXPO_W-1:0]       rsp_expo
);
   import dtsi_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   dtsi_err_type      code_ff, code_in;
   logic [COEF_W-1:0] coef_ff, coef_in;
   logic [EXPO_W-1:0] expo_ff, expo_in;

   logic [EXPO_W-1:0] frac64;
   logic [EXPO_W-1:0] headroom;
   logic [EXPO_W-1:0] expo_base;
   logic              exp_text;
   dtsi_err_type      code;

   always_comb begin
      frac64    = EXPO_W'(snap_frac);
      headroom  = NEG_MAX - snap.exp_mag;
      expo_base = snap.exp_neg ? (64'd0 - snap.exp_mag) : snap.exp_mag;
      exp_text  = snap.exp_neg || snap.exp_digit || snap.bad_exp;

      if (snap.char_count == 2'd0 || snap.sign_err) begin
         code = ERR_SIGN_EMPTY;
      end else if (snap.exp_count == 2'd2) begin
         code = ERR_MULTI_EXP;
      end else if (snap.exp_count == 2'd1 && !exp_text) begin
         code = ERR_EMPTY_EXP;
      end else if (snap.exp_count == 2'd1 &&
                   (snap.bad_exp || !snap.exp_digit || snap.exp_ovf ||
                    (!snap.exp_neg && snap.exp_mag[EXPO_W-1]))) begin
         code = ERR_BAD_EXP;
      end else if (snap.dot_count == 2'd2) begin
         code = ERR_MULTI_DOT;
      end else if (!snap.int_nonzero || (snap.dot_count == 2'd1 && snap_frac == '0)) begin
         code = ERR_INCOMPLETE;
      end else if (snap.nondigit) begin
         code = ERR_NONDIGIT;
      end else if (snap.coef == '0 && !snap.coef_ovf) begin
         code = permit_zero ? ERR_OK : ERR_ZERO;
      end else if (snap.coef_ovf) begin
         code = ERR_COEF_RANGE;
      end else if (snap.exp_neg && frac64 > headroom) begin
         code = ERR_EXP_RANGE;
      end else begin
         code = ERR_OK;
      end

      slot_free    = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      code_in      = code_ff;
      coef_in      = coef_ff;
      expo_in      = expo_ff;
      if (snap_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         code_in      = code;
         // zero value and every error give zero fields
         if (code == ERR_OK && snap.coef != '0) begin
            coef_in = snap.coef;
            expo_in = expo_base - frac64;
         end else begin
            coef_in = '0;
            expo_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      coef_ff <= coef_in;
      expo_ff <= expo_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = code_ff;
   assign rsp_coef  = coef_ff;
   assign rsp_expo  = expo_ff;

endmodule

[rtl/decimal_text_to_scaled_integer_top.sv]
// top level of the decimal text parser: input register, parser, judge, csr
// depends on dtsi_pkg, dtsi_parser and dtsi_judge
//
// Takes an unsigned decimal string, one character per item, of the form
// digits [. digits] [e|E [-] digits], and on the item with tlast gives one
// result: error code, coefficient (all mantissa digits as an integer) and
// exponent (explicit exponent minus the fraction digit count). An item with
// tuser low carries no character; with tlast it only closes the string, and
// without tlast it is dropped. One item is taken every cycle unless stalled;
// each character updates the accumulators through one multiply-by-ten and add
// in the parser stage. A result passes the input register, parse state and
// snapshot, then error priority into the result register. A waiting result
// stalls only a further last item once the snapshot stage is also full; other
// characters keep flowing. Users must write permit_zero via csr_wr_en /
// csr_wr_data only while no string is in flight; the block does not check it.
module decimal_text_to_scaled_integer_top #(
   parameter int FRACTION_COUNT_BITS = dtsi_pkg::FRACTION_COUNT_BITS
) (
   input  logic          clock,
   input  logic          reset,
   // input channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] char_code
   input  logic [0:0]    req_tuser,   // [0] char_present
   input  logic          req_tlast,   // last
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // [3:0] status, [66:4] coefficient,
                                      // [130:67] exponent, [135:131] zero
   // configuration
   input  logic          csr_wr_en,
   input  logic [0:0]    csr_wr_data  // [0] permit_zero
);
   import dtsi_pkg::*;

   // input register
   dtsi_item_type item_ff, item_in;
   logic          permit_ff, permit_in;

   // parser to judge
   logic                           consume;
   logic                           slot_free;
   logic                           snap_valid;
   dtsi_state_type                 snap;
   logic [FRACTION_COUNT_BITS-1:0] snap_frac;

   // result fields
   logic              rsp_valid;
   dtsi_err_type      rsp_code;
   logic [COEF_W-1:0] rsp_coef;
   logic [EXPO_W-1:0] rsp_expo;

   logic accept;

   // input register frees up whenever the parser takes its item
   assign req_tready = !item_ff.valid || consume;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.valid     = 1'b1;
         item_in.char_code = req_tdata;
         item_in.present   = req_tuser[0];
         item_in.last      = req_tlast;
      end else if (consume) begin
         item_in.valid = 1'b0;
      end
      permit_in = csr_wr_en ? csr_wr_data[0] : permit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
         permit_ff     <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
         permit_ff     <= permit_in;
      end
      // payload of the input register needs no reset
      item_ff.char_code <= item_in.char_code;
      item_ff.present   <= item_in.present;
      item_ff.last      <= item_in.last;
   end

   dtsi_parser #(
      .FRACTION_COUNT_BITS (FRACTION_COUNT_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item       (item_ff),
      .slot_free  (slot_free),
      .consume    (consume),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_frac  (snap_frac)
   );

   dtsi_judge #(
      .FRACTION_COUNT_BITS (FRACTION_COUNT_BITS)
   ) u_judge (
      .clock       (clock),
      .reset       (reset),
      .snap_valid  (snap_valid),
      .snap        (snap),
      .snap_frac   (snap_frac),
      .permit_zero (permit_ff),
      .rsp_ready   (rsp_tready),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_code    (rsp_code),
      .rsp_coef    (rsp_coef),
      .rsp_expo    (rsp_expo)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {5'd0, rsp_expo, rsp_coef, rsp_code};

   // any error, or a zero value, leaves coefficient and exponent at zero
   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_code != ERR_OK || rsp_coef == '0)) |->
         (rsp_coef == '0 && rsp_expo == '0))
      else $error("error or zero result with nonzero fields");

   // the input side only stalls on a last item waiting for the snapshot stage
   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (item_ff.valid && item_ff.last && snap_valid))
      else $error("input stalled without a blocked last item");

   // a parsed last item always lands in the snapshot stage
   a_last_to_snapshot: assert property (@(posedge clock) disable iff (reset)
      (consume && item_ff.last) |=> snap_valid)
      else $error("last item lost before the snapshot stage");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
